### hw/rtl/stu_pkg.sv
package stu_pkg;

    localparam int SITE_W  = 4;
    localparam int SIGN_W  = 16;
    localparam int COUNT_W = 16;
    localparam int EXP_W   = 17;
    localparam int GRP_W   = 4;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_CNOT    = 2'd1,
        FUNC_PROJECT = 2'd2,
        FUNC_EVAL    = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_APPLY = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [SITE_W-1:0] site;
        logic [SIGN_W-1:0] sign_bits;
    } in_item_t;

    typedef struct packed {
        logic [EXP_W-1:0] exponent;
        logic             weight_zero;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic apply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

endpackage

### hw/rtl/stu_controller.sv
module stu_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  stu_pkg::ctrl_status_t status,
    output stu_pkg::ctrl_cmd_t    cmd
);

    stu_pkg::state_t state_reg;
    stu_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.apply  = 1'b0;
        case (state_reg)
            stu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stu_pkg::ST_APPLY;
                end
            end
            stu_pkg::ST_APPLY: begin
                if (status.out_free) begin
                    cmd.apply  = 1'b1;
                    state_next = stu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/stu_datapath.sv
module stu_datapath #(
    parameter int QUBITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  stu_pkg::in_item_t     in_data,
    input  stu_pkg::ctrl_cmd_t    cmd,
    output stu_pkg::ctrl_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output stu_pkg::out_item_t    m_data
);

    localparam int GROUPS = (QUBITS + 7) / 8;
    localparam int PAD_W  = GROUPS * 8;
    localparam int SUM_W  = $clog2(QUBITS + 1);

    logic [QUBITS-1:0] x_reg [QUBITS];
    logic [QUBITS-1:0] z_reg [QUBITS];
    logic [QUBITS-1:0] x_next [QUBITS];
    logic [QUBITS-1:0] z_next [QUBITS];
    logic [QUBITS-1:0] sign_reg;
    logic [QUBITS-1:0] sign_next;
    logic [stu_pkg::COUNT_W-1:0] count_reg;
    logic [stu_pkg::COUNT_W-1:0] count_next;

    logic [QUBITS-1:0] site_mask;
    logic [QUBITS-1:0] tgt_mask;
    logic [QUBITS-1:0] signs_ext;
    logic [QUBITS-1:0] hit;
    logic [QUBITS-1:0] piv_oh;
    logic [QUBITS-1:0] piv_x;
    logic [QUBITS-1:0] piv_z;
    logic              piv_sign;
    logic [QUBITS-1:0] nonid;
    logic [QUBITS-1:0] zero_neg;
    logic [PAD_W-1:0]  nonid_pad;
    logic [stu_pkg::GRP_W-1:0] grp_cnt [GROUPS];

    stu_pkg::func_t    func_reg;
    logic [QUBITS-1:0] site_mask_reg;
    logic [QUBITS-1:0] tgt_mask_reg;
    logic [QUBITS-1:0] signs_reg;
    logic [QUBITS-1:0] hit_reg;
    logic [QUBITS-1:0] piv_oh_reg;
    logic [QUBITS-1:0] piv_x_reg;
    logic [QUBITS-1:0] piv_z_reg;
    logic              piv_sign_reg;
    logic              found_reg;
    logic              wz_reg;
    logic [stu_pkg::GRP_W-1:0] grp_cnt_reg [GROUPS];

    logic [SUM_W-1:0]   total;
    stu_pkg::out_item_t result;
    logic               out_valid_reg;
    stu_pkg::out_item_t out_data_reg;

    // Qubits beyond the width of the input fields never match a site and get a zero sign.
    for (genvar i = 0; i < QUBITS; i++) begin : g_mask
        if (i < stu_pkg::SIGN_W) begin : g_low
            assign site_mask[i] = (in_data.site == stu_pkg::SITE_W'(i));
            assign signs_ext[i] = in_data.sign_bits[i];
        end else begin : g_high
            assign site_mask[i] = 1'b0;
            assign signs_ext[i] = 1'b0;
        end
    end

    assign tgt_mask = {site_mask[QUBITS-2:0], site_mask[QUBITS-1]};

    always_comb begin
        piv_x    = '0;
        piv_z    = '0;
        piv_sign = 1'b0;
        for (int i = 0; i < QUBITS; i++) begin
            hit[i]      = |(z_reg[i] & site_mask);
            nonid[i]    = |x_reg[i];
            zero_neg[i] = ~nonid[i] & ((^(z_reg[i] & signs_ext)) ^ sign_reg[i]);
        end
        piv_oh = hit & (~hit + 1'b1);
        for (int i = 0; i < QUBITS; i++) begin
            piv_x    = piv_x | ({QUBITS{piv_oh[i]}} & x_reg[i]);
            piv_z    = piv_z | ({QUBITS{piv_oh[i]}} & z_reg[i]);
            piv_sign = piv_sign | (piv_oh[i] & sign_reg[i]);
        end
        nonid_pad = PAD_W'(nonid);
        for (int g = 0; g < GROUPS; g++) begin
            grp_cnt[g] = '0;
            for (int b = 0; b < 8; b++) begin
                grp_cnt[g] = grp_cnt[g] + stu_pkg::GRP_W'(nonid_pad[g*8+b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg      <= stu_pkg::func_t'(in_data.func);
            site_mask_reg <= site_mask;
            tgt_mask_reg  <= tgt_mask;
            signs_reg     <= signs_ext;
            hit_reg       <= hit;
            piv_oh_reg    <= piv_oh;
            piv_x_reg     <= piv_x;
            piv_z_reg     <= piv_z;
            piv_sign_reg  <= piv_sign;
            found_reg     <= |hit;
            wz_reg        <= |zero_neg;
            grp_cnt_reg   <= grp_cnt;
        end
    end

    always_comb begin
        x_next     = x_reg;
        z_next     = z_reg;
        sign_next  = sign_reg;
        count_next = count_reg;
        total      = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total = total + SUM_W'(grp_cnt_reg[g]);
        end
        case (func_reg)
            stu_pkg::FUNC_START: begin
                for (int i = 0; i < QUBITS; i++) begin
                    x_next[i]    = '0;
                    z_next[i]    = '0;
                    z_next[i][i] = 1'b1;
                end
                sign_next  = signs_reg;
                count_next = '0;
            end
            stu_pkg::FUNC_CNOT: begin
                for (int i = 0; i < QUBITS; i++) begin
                    if (|(x_reg[i] & site_mask_reg)) begin
                        x_next[i] = x_reg[i] ^ tgt_mask_reg;
                    end
                    if (|(z_reg[i] & tgt_mask_reg)) begin
                        z_next[i] = z_reg[i] ^ site_mask_reg;
                    end
                end
            end
            stu_pkg::FUNC_PROJECT: begin
                for (int i = 0; i < QUBITS; i++) begin
                    if (piv_oh_reg[i]) begin
                        x_next[i]    = site_mask_reg;
                        z_next[i]    = '0;
                        sign_next[i] = 1'b0;
                    end else if (hit_reg[i]) begin
                        x_next[i]    = x_reg[i] ^ piv_x_reg;
                        z_next[i]    = z_reg[i] ^ piv_z_reg;
                        sign_next[i] = sign_reg[i] ^ piv_sign_reg;
                    end
                end
                if (found_reg && (count_reg != '1)) begin
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
        result.weight_zero = 1'b0;
        result.exponent    = stu_pkg::EXP_W'(count_next);
        if (func_reg == stu_pkg::FUNC_EVAL) begin
            result.weight_zero = wz_reg;
            result.exponent    = wz_reg ? '0
                               : stu_pkg::EXP_W'(count_reg) + stu_pkg::EXP_W'(total);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUBITS; i++) begin
                x_reg[i] <= '0;
                z_reg[i] <= QUBITS'(1) << i;
            end
            sign_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.apply) begin
            x_reg     <= x_next;
            z_reg     <= z_next;
            sign_reg  <= sign_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            out_data_reg <= result;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_data_reg;

endmodule

### hw/rtl/stabilizer_tableau_update_core.sv
// Stabilizer tableau engine over a ring of QUBITS qubits.
// The input channel (s_valid, s_ready, s_data) carries one command per
// transaction: start with signs, CNOT at a site, X projection at a site, or
// evaluate weight. Every command yields exactly one result transaction on the
// output channel (m_valid, m_ready, m_data) with the exponent and the
// weight-zero flag.
// A command is analysed in the cycle it is accepted (pivot search, row
// parities and group counts are registered at the accepting edge) and applied
// once the output register is free; the apply edge also loads the output
// register, which then offers the result. A new command is accepted only
// after the previous one has been applied.
// The output register lets a new command be accepted while the previous result
// still waits; if the receiver stalls, the apply step waits until the output
// register frees, and no further command is accepted meanwhile.
// Reset clears the X rows, sets the Z rows to the identity, clears the signs
// and the projection count, and empties the output register.
module stabilizer_tableau_update_core #(
    parameter int QUBITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stu_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stu_pkg::out_item_t m_data
);

    stu_pkg::ctrl_cmd_t    cmd;
    stu_pkg::ctrl_status_t status;

    stu_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stu_datapath #(
        .QUBITS (QUBITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### hw/rtl/stu_checker.sv
module stu_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input stu_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result transaction changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted a transaction while one was in progress.");

    a_wz_exponent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.weight_zero |-> m_data.exponent == '0)
        else $error("Weight-zero result carries a non-zero exponent.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2) || $past(m_valid))
        else $error("Result appeared without an accepted transaction.");

endmodule

bind stabilizer_tableau_update_core stu_checker u_stu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
